// File: rtl/set_assoc_lru_cache_prefetch_defines.svh
// Assertion macros for the set-associative cache block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef SET_ASSOC_LRU_CACHE_PREFETCH_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_PREFETCH_DEFINES_SVH

// same-cycle implication
`define SALC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SALC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/salc_pkg.sv
// Shared types and constants for the set-associative cache block.
// No dependencies.
package salc_pkg;

    localparam int ADDR_W  = 32;
    localparam int DATA_W  = 32;
    localparam int STAMP_W = 32;
    localparam int CNT_W   = 32;

    // register indexes on the config port
    localparam logic [1:0] REG_WAYS_LOG2   = 2'd0;
    localparam logic [1:0] REG_ALLOC_STORE = 2'd1;
    localparam logic [1:0] REG_PF_MODE     = 2'd2;

    // prefetch modes
    localparam logic [1:0] PF_NONE = 2'd0;
    localparam logic [1:0] PF_ALL  = 2'd1;
    localparam logic [1:0] PF_MISS = 2'd2;

    localparam logic MODE_LOAD = 1'b0;

    localparam logic [2:0] WAYS_LOG2_RST   = 3'd1;
    localparam logic       ALLOC_STORE_RST = 1'b1;

    typedef struct packed {
        logic load;
        logic step;
    } lru_ctrl_t;

endpackage

// File: rtl/salc_lru_unit.sv
// Iterative LRU victim search: one tree level of stamp compares per step.
// Depends on salc_pkg.
module salc_lru_unit #(
    parameter int ROW_WAYS = 16,
    localparam int SLOT_W  = ($clog2(ROW_WAYS) > 0) ? $clog2(ROW_WAYS) : 1
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  salc_pkg::lru_ctrl_t                         ctrl,
    input  logic [ROW_WAYS-1:0]                         in_set,
    input  logic [ROW_WAYS-1:0][salc_pkg::STAMP_W-1:0] stamps,
    output logic [SLOT_W-1:0]                           victim,
    output logic                                        done
);
    import salc_pkg::*;

    localparam int LEVELS = $clog2(ROW_WAYS);
    localparam int LVL_W  = (LEVELS > 0) ? $clog2(LEVELS + 1) : 1;

    logic [ROW_WAYS-1:0]               p_reg, p_next;
    logic [ROW_WAYS-1:0][STAMP_W-1:0]  s_reg, s_next;
    logic [ROW_WAYS-1:0][SLOT_W-1:0]   i_reg, i_next;
    logic [LVL_W-1:0]                  lvl_reg, lvl_next;

    always_comb
    begin
        p_next   = p_reg;
        s_next   = s_reg;
        i_next   = i_reg;
        lvl_next = lvl_reg;
        if (ctrl.load)
        begin
            for (int j = 0; j < ROW_WAYS; j++)
            begin
                p_next[j] = in_set[j];
                s_next[j] = stamps[j];
                i_next[j] = SLOT_W'(j);
            end
            lvl_next = '0;
        end
        else if (ctrl.step)
        begin
            // pairwise min; left wins ties so the lowest way is kept
            for (int i = 0; i < ROW_WAYS / 2; i++)
            begin
                if (!p_reg[2*i] || (p_reg[2*i+1] && (s_reg[2*i+1] < s_reg[2*i])))
                begin
                    p_next[i] = p_reg[2*i+1];
                    s_next[i] = s_reg[2*i+1];
                    i_next[i] = i_reg[2*i+1];
                end
                else
                begin
                    p_next[i] = p_reg[2*i];
                    s_next[i] = s_reg[2*i];
                    i_next[i] = i_reg[2*i];
                end
            end
            lvl_next = lvl_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        s_reg <= s_next;
        i_reg <= i_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_reg <= '0;
        end
        else
        begin
            lvl_reg <= lvl_next;
        end
    end

    assign victim = i_reg[0];
    assign done   = (lvl_reg == LVL_W'(LEVELS));

endmodule

// File: rtl/set_assoc_lru_cache_prefetch.sv
// Set-associative tag cache with LRU replacement and next-line prefetch.
// Each lookup reads the row (S_READ), then compares and writes (S_EVAL); a fill into a full
// set first searches for the LRU victim in salc_lru_unit (S_REDUCE). A request runs one lookup,
// or two with prefetch; busy stays high until the registered done strobe, no output stall.
// After reset a clearing pass over all rows runs with busy high.
// Depends on salc_pkg, salc_lru_unit and the defines header.
`include "set_assoc_lru_cache_prefetch_defines.svh"

module set_assoc_lru_cache_prefetch #(
    parameter int TOTAL_LINES = 512,   // power of two
    parameter int MAX_WAYS    = 16,
    parameter int LINE_BYTES  = 32     // power of two
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request
    input  logic                          start,
    output logic                          busy,
    input  logic                          mode,
    input  logic [salc_pkg::ADDR_W-1:0]   address,
    // result
    output logic                          done,
    output logic                          hit,
    output logic                          allocated,
    output logic                          prefetched,
    output logic [salc_pkg::CNT_W-1:0]    hit_count,
    output logic [salc_pkg::CNT_W-1:0]    access_count,
    // config
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [salc_pkg::DATA_W-1:0]   pwdata,
    output logic [salc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import salc_pkg::*;

    localparam int OFFS_W   = $clog2(LINE_BYTES);
    localparam int BLK_W    = ADDR_W - OFFS_W;
    localparam int LINE_W   = $clog2(TOTAL_LINES);
    localparam int MW_POW   = 2 ** ($clog2(MAX_WAYS + 1) - 1);
    localparam int ROW_WAYS = (MW_POW < TOTAL_LINES) ? MW_POW : TOTAL_LINES;
    localparam int RW_LOG2  = $clog2(ROW_WAYS);
    localparam int SLOT_W   = (RW_LOG2 > 0) ? RW_LOG2 : 1;
    localparam int ROWS     = TOTAL_LINES / ROW_WAYS;
    localparam int ROW_AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ENT_W    = 1 + BLK_W + STAMP_W;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_EVAL   = 3'd3;
    localparam logic [2:0] S_REDUCE = 3'd4;

    // one row holds ROW_WAYS lines; a set never straddles rows
    logic [ROW_WAYS-1:0][ENT_W-1:0] mem [ROWS];
    logic [ROW_WAYS-1:0][ENT_W-1:0] rd_row_reg;
    logic [ROW_WAYS-1:0][ENT_W-1:0] wr_row;
    logic [ROW_WAYS-1:0][ENT_W-1:0] mem_wdata;
    logic                           mem_we;
    logic [ROW_AW-1:0]              mem_waddr;

    logic [2:0]         state_reg, state_next;
    logic [ROW_AW-1:0]  clr_row_reg, clr_row_next;
    logic [2:0]         ways_log2_reg, ways_log2_next;
    logic               alloc_store_reg, alloc_store_next;
    logic [1:0]         pf_mode_reg, pf_mode_next;
    logic [STAMP_W-1:0] stamp_clock_reg, stamp_clock_next;
    logic [CNT_W-1:0]   hits_total_reg, hits_total_next;
    logic [CNT_W-1:0]   accesses_total_reg, accesses_total_next;
    logic [BLK_W-1:0]   blk_reg, blk_next;
    logic               mode_reg, mode_next;
    logic               phase_reg, phase_next;
    logic               hit_d_reg, hit_d_next;
    logic               alloc_d_reg, alloc_d_next;
    logic               done_reg, done_next;
    logic               hit_reg, hit_next;
    logic               allocated_reg, allocated_next;
    logic               prefetched_reg, prefetched_next;

    logic [2:0]          eff_k;
    logic [LINE_W-1:0]   base;
    logic [ROW_AW-1:0]   row_addr;
    logic [SLOT_W-1:0]   off;
    logic [SLOT_W-1:0]   wmask;

    logic [ROW_WAYS-1:0]              valid_v, in_set, hit_v, inv_v;
    logic [ROW_WAYS-1:0][BLK_W-1:0]   tag_v;
    logic [ROW_WAYS-1:0][STAMP_W-1:0] stamp_v;
    logic [SLOT_W-1:0]                hit_slot, inv_slot, wr_slot, lru_victim;
    logic                             any_hit, any_inv, may_fill, lru_done;
    logic                             wr_en, wr_fill, touch_done, cur_hit, cur_fill;
    logic                             pf_go, fin_hit, cfg_wr;
    logic [STAMP_W-1:0]               new_stamp;
    lru_ctrl_t                        lru_ctrl;

    // set geometry
    assign eff_k    = (ways_log2_reg > 3'(RW_LOG2)) ? 3'(RW_LOG2) : ways_log2_reg;
    assign base     = blk_reg[LINE_W-1:0] << eff_k;
    assign row_addr = ROW_AW'(base >> RW_LOG2);
    assign off      = SLOT_W'(base & LINE_W'(ROW_WAYS - 1));
    assign wmask    = SLOT_W'((1 << eff_k) - 1);

    always_comb
    begin
        for (int j = 0; j < ROW_WAYS; j++)
        begin
            valid_v[j] = rd_row_reg[j][ENT_W-1];
            tag_v[j]   = rd_row_reg[j][ENT_W-2 -: BLK_W];
            stamp_v[j] = rd_row_reg[j][STAMP_W-1:0];
            in_set[j]  = ((SLOT_W'(j) & ~wmask) == off);
            hit_v[j]   = in_set[j] && valid_v[j] && (tag_v[j] == blk_reg);
            inv_v[j]   = in_set[j] && !valid_v[j];
        end
    end

    // lowest matching way wins
    always_comb
    begin
        hit_slot = '0;
        inv_slot = '0;
        for (int j = ROW_WAYS - 1; j >= 0; j--)
        begin
            if (hit_v[j])
            begin
                hit_slot = SLOT_W'(j);
            end
            if (inv_v[j])
            begin
                inv_slot = SLOT_W'(j);
            end
        end
    end

    assign any_hit   = |hit_v;
    assign any_inv   = |inv_v;
    assign may_fill  = phase_reg || (mode_reg == MODE_LOAD) || alloc_store_reg;
    assign new_stamp = stamp_clock_reg + 1'b1;

    salc_lru_unit #(
        .ROW_WAYS (ROW_WAYS)
    ) u_lru (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (lru_ctrl),
        .in_set (in_set),
        .stamps (stamp_v),
        .victim (lru_victim),
        .done   (lru_done)
    );

    // lookup sequencing
    always_comb
    begin
        wr_en      = 1'b0;
        wr_fill    = 1'b0;
        wr_slot    = hit_slot;
        touch_done = 1'b0;
        cur_hit    = 1'b0;
        cur_fill   = 1'b0;
        lru_ctrl   = '0;
        unique case (state_reg)
            S_EVAL:
            begin
                if (any_hit)
                begin
                    wr_en      = 1'b1;
                    touch_done = 1'b1;
                    cur_hit    = 1'b1;
                end
                else if (!may_fill)
                begin
                    touch_done = 1'b1;
                end
                else if (any_inv)
                begin
                    wr_en      = 1'b1;
                    wr_fill    = 1'b1;
                    wr_slot    = inv_slot;
                    touch_done = 1'b1;
                    cur_fill   = 1'b1;
                end
                else
                begin
                    lru_ctrl.load = 1'b1;
                end
            end
            S_REDUCE:
            begin
                if (lru_done)
                begin
                    wr_en      = 1'b1;
                    wr_fill    = 1'b1;
                    wr_slot    = lru_victim;
                    touch_done = 1'b1;
                    cur_fill   = 1'b1;
                end
                else
                begin
                    lru_ctrl.step = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        for (int j = 0; j < ROW_WAYS; j++)
        begin
            wr_row[j] = rd_row_reg[j];
            if (SLOT_W'(j) == wr_slot)
            begin
                wr_row[j] = {1'b1, (wr_fill ? blk_reg : tag_v[j]), new_stamp};
            end
        end
    end

    assign mem_we    = wr_en || (state_reg == S_CLEAR);
    assign mem_waddr = (state_reg == S_CLEAR) ? clr_row_reg : row_addr;
    assign mem_wdata = (state_reg == S_CLEAR) ? '0 : wr_row;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == S_READ)
        begin
            rd_row_reg <= mem[row_addr];
        end
    end

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pf_go  = (pf_mode_reg == PF_ALL) || ((pf_mode_reg == PF_MISS) && !cur_hit);
    assign fin_hit = phase_reg ? hit_d_reg : cur_hit;

    always_comb
    begin
        state_next          = state_reg;
        clr_row_next        = clr_row_reg;
        ways_log2_next      = ways_log2_reg;
        alloc_store_next    = alloc_store_reg;
        pf_mode_next        = pf_mode_reg;
        stamp_clock_next    = stamp_clock_reg;
        hits_total_next     = hits_total_reg;
        accesses_total_next = accesses_total_reg;
        blk_next            = blk_reg;
        mode_next           = mode_reg;
        phase_next          = phase_reg;
        hit_d_next          = hit_d_reg;
        alloc_d_next        = alloc_d_reg;
        done_next           = 1'b0;
        hit_next            = hit_reg;
        allocated_next      = allocated_reg;
        prefetched_next     = prefetched_reg;

        if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_WAYS_LOG2:   ways_log2_next   = pwdata[2:0];
                REG_ALLOC_STORE: alloc_store_next = pwdata[0];
                REG_PF_MODE:     pf_mode_next     = pwdata[1:0];
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_row_next = clr_row_reg + 1'b1;
                if (clr_row_reg == ROW_AW'(ROWS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    blk_next   = address[ADDR_W-1:OFFS_W];
                    mode_next  = mode;
                    phase_next = 1'b0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (lru_ctrl.load)
                begin
                    state_next = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (wr_en)
        begin
            stamp_clock_next = new_stamp;
        end

        if (touch_done)
        begin
            if (!phase_reg && pf_go)
            begin
                // demand part done, run the next-line lookup
                hit_d_next   = cur_hit;
                alloc_d_next = cur_fill;
                phase_next   = 1'b1;
                blk_next     = blk_reg + 1'b1;
                state_next   = S_READ;
            end
            else
            begin
                done_next       = 1'b1;
                hit_next        = fin_hit;
                allocated_next  = phase_reg ? alloc_d_reg : cur_fill;
                prefetched_next = phase_reg && cur_fill;
                state_next      = S_IDLE;
                if (fin_hit && (hits_total_reg != '1))
                begin
                    hits_total_next = hits_total_reg + 1'b1;
                end
                if (accesses_total_reg != '1)
                begin
                    accesses_total_next = accesses_total_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_CLEAR;
            clr_row_reg        <= '0;
            ways_log2_reg      <= WAYS_LOG2_RST;
            alloc_store_reg    <= ALLOC_STORE_RST;
            pf_mode_reg        <= PF_NONE;
            stamp_clock_reg    <= '0;
            hits_total_reg     <= '0;
            accesses_total_reg <= '0;
            blk_reg            <= '0;
            mode_reg           <= 1'b0;
            phase_reg          <= 1'b0;
            hit_d_reg          <= 1'b0;
            alloc_d_reg        <= 1'b0;
            done_reg           <= 1'b0;
            hit_reg            <= 1'b0;
            allocated_reg      <= 1'b0;
            prefetched_reg     <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            clr_row_reg        <= clr_row_next;
            ways_log2_reg      <= ways_log2_next;
            alloc_store_reg    <= alloc_store_next;
            pf_mode_reg        <= pf_mode_next;
            stamp_clock_reg    <= stamp_clock_next;
            hits_total_reg     <= hits_total_next;
            accesses_total_reg <= accesses_total_next;
            blk_reg            <= blk_next;
            mode_reg           <= mode_next;
            phase_reg          <= phase_next;
            hit_d_reg          <= hit_d_next;
            alloc_d_reg        <= alloc_d_next;
            done_reg           <= done_next;
            hit_reg            <= hit_next;
            allocated_reg      <= allocated_next;
            prefetched_reg     <= prefetched_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        case (paddr[3:2])
            REG_WAYS_LOG2:   prdata = DATA_W'(ways_log2_reg);
            REG_ALLOC_STORE: prdata = DATA_W'(alloc_store_reg);
            REG_PF_MODE:     prdata = DATA_W'(pf_mode_reg);
            default:         prdata = '0;
        endcase
    end

    assign pready       = 1'b1;
    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign hit          = hit_reg;
    assign allocated    = allocated_reg;
    assign prefetched   = prefetched_reg;
    assign hit_count    = hits_total_reg;
    assign access_count = accesses_total_reg;

    `SALC_ASSERT_NXT(a_accept_goes_busy, start && !busy, busy, "request did not raise busy")
    `SALC_ASSERT_IMP(a_done_from_lookup, done, $past(touch_done), "done without a finished lookup")
    `SALC_ASSERT_NXT(a_done_one_cycle, done, !done, "done strobe longer than one cycle")
    `SALC_ASSERT_IMP(a_hits_within_accesses, 1'b1, hit_count <= access_count, "hits above accesses")

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Testbench for set_assoc_lru_cache_prefetch: drives loads and stores through the start/busy
// port and sets the registers over APB. A scoreboard class holds its own tag/LRU copy.
// Depends on salc_pkg and the RTL of the block.

module testbench;

    import salc_pkg::*;

    localparam int TOTAL_LINES   = 512;
    localparam int MAX_WAYS_LOG2 = 4;      // 16 ways
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 16;     // covers the longest lookup with prefetch
    localparam int PHASE_ITEMS   = 240;
    localparam int CALM_ITEMS    = 150;    // tail of the run without idling
    localparam logic       MODE_STORE  = 1'b1;
    localparam logic [1:0] PF_RESERVED = 2'd3;

    typedef struct packed {
        logic        hit;
        logic        allocated;
        logic        prefetched;
        logic [31:0] hit_count;
        logic [31:0] access_count;
    } cache_result_t;

    class cache_scoreboard;
        logic [26:0]   block_of [TOTAL_LINES];
        bit            valid_of [TOTAL_LINES];
        logic [31:0]   stamp_of [TOTAL_LINES];
        logic [31:0]   stamp_now;
        logic [31:0]   hit_total;
        logic [31:0]   access_total;
        logic [2:0]    ways_log2_q;
        logic          alloc_store_q;
        logic [1:0]    pf_mode_q;
        cache_result_t pending_q[$];
        int            mismatches;
        int            results_seen;
        int            hits_seen;

        function new();
            foreach (valid_of[i])
            begin
                valid_of[i] = 1'b0;
                stamp_of[i] = '0;
            end
            stamp_now     = '0;
            hit_total     = '0;
            access_total  = '0;
            ways_log2_q   = WAYS_LOG2_RST;
            alloc_store_q = ALLOC_STORE_RST;
            pf_mode_q     = PF_NONE;
            mismatches    = 0;
            results_seen  = 0;
            hits_seen     = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_WAYS_LOG2:   ways_log2_q   = value[2:0];
                REG_ALLOC_STORE: alloc_store_q = value[0];
                REG_PF_MODE:     pf_mode_q     = value[1:0];
                default: ;
            endcase
        endfunction

        // Look up one block in its set; fill on a miss when allowed. Returns hit.
        function bit lookup_block(logic [26:0] blk, bit may_fill, output bit filled);
            int          ways;
            int          sets;
            int          base;
            int          victim;
            bit          found_free;
            logic [31:0] oldest;
            ways   = 1 << ((ways_log2_q > MAX_WAYS_LOG2) ? MAX_WAYS_LOG2 : ways_log2_q);
            sets   = TOTAL_LINES / ways;
            base   = (int'(blk[8:0]) % sets) * ways;
            filled = 1'b0;
            for (int w = 0; w < ways; w++)
            begin
                if (valid_of[base + w] && block_of[base + w] == blk)
                begin
                    stamp_now = stamp_now + 1;
                    stamp_of[base + w] = stamp_now;
                    return 1'b1;
                end
            end
            if (!may_fill)
                return 1'b0;
            victim     = 0;
            found_free = 1'b0;
            for (int w = 0; w < ways; w++)
            begin
                if (!found_free && !valid_of[base + w])
                begin
                    victim     = w;
                    found_free = 1'b1;
                end
            end
            if (!found_free)
            begin
                oldest = stamp_of[base];
                for (int w = 1; w < ways; w++)
                begin
                    if (stamp_of[base + w] < oldest)
                    begin
                        oldest = stamp_of[base + w];
                        victim = w;
                    end
                end
            end
            stamp_now = stamp_now + 1;
            stamp_of[base + victim] = stamp_now;
            block_of[base + victim] = blk;
            valid_of[base + victim] = 1'b1;
            filled = 1'b1;
            return 1'b0;
        endfunction

        function void note_request(logic m, logic [31:0] addr);
            cache_result_t exp_r;
            logic [26:0]   blk;
            bit            may_fill;
            bit            got_hit;
            bit            alloc_f;
            bit            pf_f;
            blk      = addr[31:5];
            may_fill = (m == MODE_LOAD) || alloc_store_q;
            got_hit  = lookup_block(blk, may_fill, alloc_f);
            pf_f     = 1'b0;
            // block after the last one wraps to 0 through the 27-bit add
            if (pf_mode_q == PF_ALL || (pf_mode_q == PF_MISS && !got_hit))
                void'(lookup_block(blk + 27'd1, 1'b1, pf_f));
            if (got_hit && hit_total != 32'hFFFF_FFFF)
                hit_total = hit_total + 1;
            if (access_total != 32'hFFFF_FFFF)
                access_total = access_total + 1;
            exp_r.hit          = got_hit;
            exp_r.allocated    = alloc_f;
            exp_r.prefetched   = pf_f;
            exp_r.hit_count    = hit_total;
            exp_r.access_count = access_total;
            pending_q = {pending_q, exp_r};
        endfunction

        function void check_result(cache_result_t got);
            cache_result_t exp_r;
            results_seen++;
            if (got.hit)
                hits_seen++;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result: %p", $realtime, got);
                return;
            end
            exp_r = pending_q.pop_front();
            if (got !== exp_r)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] result %0d mismatch: expected %p, got %p",
                             $realtime, results_seen, exp_r, got);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        mode = MODE_LOAD;
    logic [31:0] address = '0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic        busy;
    logic        done;
    logic        hit;
    logic        allocated;
    logic        prefetched;
    logic [31:0] hit_count;
    logic [31:0] access_count;
    logic [31:0] prdata;
    logic        pready;

    cache_scoreboard sb = new();
    int cycle_count = 0;
    int requests_sent = 0;
    int settings_used = 1;

    set_assoc_lru_cache_prefetch u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .address      (address),
        .done         (done),
        .hit          (hit),
        .allocated    (allocated),
        .prefetched   (prefetched),
        .hit_count    (hit_count),
        .access_count (access_count),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result({hit, allocated, prefetched, hit_count, access_count});
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // gap > 0 first idles the request side with start held low
    task automatic send_request(logic m, logic [31:0] addr, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        mode    <= m;
        address <= addr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(m, addr);
        requests_sent++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (sb.pending_q.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // leaves the bus selected; the caller closes the last transfer
    task automatic write_register(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_register(idx, value);
    endtask

    task automatic apply_settings(logic [2:0] wl, logic al, logic [1:0] pf);
        wait_idle();
        write_register(REG_WAYS_LOG2, 32'(wl));
        write_register(REG_ALLOC_STORE, 32'(al));
        write_register(REG_PF_MODE, 32'(pf));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_used++;
    endtask

    // Hot set window with a few more tags than ways, so both hits and evictions occur.
    task automatic run_phase(int n_items, bit calm_tail);
        logic [17:0] tags [24];
        int          n_tags;
        int          set_base;
        int          pick;
        int          gap;
        logic        m;
        logic [31:0] addr;
        bit          calm;
        foreach (tags[i])
            tags[i] = 18'($urandom);
        n_tags   = (1 << ((sb.ways_log2_q > MAX_WAYS_LOG2) ? MAX_WAYS_LOG2 : sb.ways_log2_q)) + 3;
        set_base = $urandom_range(0, TOTAL_LINES - 4);
        for (int i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(0, 99);
            m    = 1'($urandom_range(0, 1));
            calm = calm_tail && (i >= n_items - CALM_ITEMS);
            if (pick < 80)
                addr = {tags[$urandom_range(0, n_tags - 1)],
                        9'(set_base + $urandom_range(0, 3)), 5'($urandom_range(0, 31))};
            else if (pick < 90)
                addr = {18'h3FFFF, 9'(TOTAL_LINES - 1 - $urandom_range(0, 3)),
                        5'($urandom_range(0, 31))};
            else
                addr = $urandom;
            gap = 0;
            if (!calm && $urandom_range(0, 5) == 0)
                gap = $urandom_range(1, 15);
            send_request(m, addr, gap);
            if (!calm && i == n_items / 2 && $urandom_range(0, 1) == 0)
                wait_idle();
        end
    endtask

    initial
    begin
        logic [2:0] wl_list [8];
        logic       al_list [8];
        logic [1:0] pf_list [8];
        wl_list = '{3'd0, 3'd4, 3'd7, 3'd2, 3'd3, 3'd5, 3'd1, 3'd6};
        al_list = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
        pf_list = '{PF_ALL, PF_MISS, PF_RESERVED, PF_MISS,
                    PF_ALL, PF_NONE, PF_MISS, PF_ALL};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);

        // reset settings: 2 ways, allocate on stores, no prefetch
        send_request(MODE_LOAD,  32'h0000_0000, 0);
        send_request(MODE_LOAD,  32'h0000_001F, 0);
        send_request(MODE_STORE, 32'h0000_0020, 0);
        send_request(MODE_LOAD,  32'hFFFF_FFFF, 0);
        send_request(MODE_STORE, 32'hFFFF_FFE0, 0);
        send_request(MODE_LOAD,  32'h0000_2000, 0);
        send_request(MODE_LOAD,  32'h0000_4000, 0);   // full set, evicts LRU
        send_request(MODE_LOAD,  32'h0000_0000, 0);

        // store misses without fill; prefetch on miss still runs
        apply_settings(3'd1, 1'b0, PF_MISS);
        send_request(MODE_STORE, 32'h0001_0000, 0);
        send_request(MODE_STORE, 32'h0001_0020, 0);
        send_request(MODE_STORE, 32'h0001_0000, 0);
        send_request(MODE_LOAD,  32'hFFFF_FFC0, 0);
        send_request(MODE_LOAD,  32'hFFFF_FFE5, 0);

        // direct mapped, prefetch always: next block after the top wraps to 0
        apply_settings(3'd0, 1'b1, PF_ALL);
        send_request(MODE_LOAD,  32'hFFFF_FFFF, 0);
        send_request(MODE_STORE, 32'h0000_0004, 0);
        send_request(MODE_LOAD,  32'h0000_4000, 0);
        send_request(MODE_STORE, 32'h0000_0000, 0);

        // oversized associativity clamps to 16 ways; reserved prefetch mode is off
        apply_settings(3'd7, 1'b0, PF_RESERVED);
        send_request(MODE_LOAD,  32'h0000_0000, 0);
        send_request(MODE_STORE, 32'h0000_2000, 0);
        send_request(MODE_LOAD,  32'h0000_0020, 0);
        send_request(MODE_STORE, 32'h8000_0000, 0);
        send_request(MODE_LOAD,  32'h7FFF_FFFF, 0);

        // settings change without flush between phases
        for (int p = 0; p < 8; p++)
        begin
            apply_settings(wl_list[p], al_list[p], pf_list[p]);
            run_phase(PHASE_ITEMS, p == 7);
        end

        start <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d loads/stores under %0d register settings; %0d results checked,",
                 requests_sent, settings_used, sb.results_seen);
        $display("%0d demand hits, %0d mismatches", sb.hits_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
